// ===== rtl/tasp_pkg.sv =====
// package for the tagged a-law sample packer
// types, register indexes, formats and encoder functions; no dependencies
`default_nettype none
package tasp_pkg;

    localparam int MaxChannelsDefault = 32;
    localparam int CodeDepth          = 32;

    // register indexes
    localparam logic [2:0] RegFormat    = 3'd0;
    localparam logic [2:0] RegChanEn    = 3'd1;
    localparam logic [2:0] RegQuietLvl  = 3'd2;
    localparam logic [2:0] RegQuietFrm  = 3'd3;
    localparam logic [2:0] RegStampIntv = 3'd4;

    // formats
    localparam logic [2:0] FmtRaw    = 3'd0;
    localparam logic [2:0] FmtSigned = 3'd1;
    localparam logic [2:0] FmtAlaw   = 3'd2;
    localparam logic [2:0] FmtXlaw   = 3'd3;
    localparam logic [2:0] FmtBits   = 3'd4;
    localparam logic [2:0] FmtTagged = 3'd5;

    localparam logic [7:0] EscByte = 8'h55;

    typedef struct packed {
        logic [11:0] sample;
        logic [4:0]  channel;
        logic        frame_end;
        logic [63:0] now_usec;
    } t_in_word;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
    } t_out_word;

    // byte source selected by the controller
    typedef enum logic [2:0] {
        SRC_LO    = 3'd0,
        SRC_HI    = 3'd1,
        SRC_CODE  = 3'd2,
        SRC_ESC   = 3'd3,
        SRC_ZERO  = 3'd4,
        SRC_STAMP = 3'd5,
        SRC_MEM   = 3'd6
    } t_src;

    // commands from controller to datapath
    typedef struct packed {
        logic       load;      // capture accepted word
        logic       emit;      // present a byte
        t_src       src;
        logic       last;
        logic       stamp_nxt; // next stamp byte
        logic       mem_nxt;   // next buffered code
        logic       frame_upd; // apply frame end to state
        logic       tag_stamp; // update next_stamp from now
        logic       drop;      // dropped frame, clear next_stamp
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic       en;
        logic [2:0] fmt;
        logic       fend;
        logic       full;
        logic       drop;       // computed quiet decision
        logic       stamp_due;
        logic [5:0] fill;
        logic [2:0] stamp_idx;
        logic [5:0] mem_idx;
        logic       out_busy;
    } t_sts;

    // a-law code of a centred value
    function automatic logic [7:0] enc_alaw(input logic signed [12:0] v);
        logic [7:0]  sign;
        logic [11:0] m;
        logic [3:0]  e;
        logic [7:0]  c;
        sign = (v < 0) ? 8'h00 : 8'h80;
        m    = (v < 0) ? 12'(-v) : 12'(v);
        if (m <= 12'h00F) begin
            c = 8'(m) | sign;
        end else begin
            if (m > 12'h7FF) m = 12'h7FF;
            // leading-one position gives the exponent
            if (m[10])      begin e = 4'd7; m = m >> 6; end
            else if (m[9])  begin e = 4'd6; m = m >> 5; end
            else if (m[8])  begin e = 4'd5; m = m >> 4; end
            else if (m[7])  begin e = 4'd4; m = m >> 3; end
            else if (m[6])  begin e = 4'd3; m = m >> 2; end
            else if (m[5])  begin e = 4'd2; m = m >> 1; end
            else            begin e = 4'd1; end
            c = {1'b0, e[2:0], m[3:0]} | sign;
        end
        return c ^ EscByte;
    endfunction

    // unsigned x-law code of a raw sample
    function automatic logic [7:0] enc_xlaw(input logic [11:0] v);
        logic [11:0] m;
        logic [2:0]  e;
        logic [7:0]  c;
        m = v;
        if (v <= 12'h01F) begin
            c = 8'(v);
        end else begin
            if (m[11])      begin e = 3'd7; m = m >> 6; end
            else if (m[10]) begin e = 3'd6; m = m >> 5; end
            else if (m[9])  begin e = 3'd5; m = m >> 4; end
            else if (m[8])  begin e = 3'd4; m = m >> 3; end
            else if (m[7])  begin e = 3'd3; m = m >> 2; end
            else if (m[6])  begin e = 3'd2; m = m >> 1; end
            else            begin e = 3'd1; end
            c = {e, m[4:0]};
        end
        return c;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/tasp_datapath.sv =====
// datapath of the tagged a-law sample packer: registers, code buffer,
// encoders and output register; depends on tasp_pkg
`default_nettype none
module tasp_datapath #(
    parameter int MAX_CHANNELS = tasp_pkg::MaxChannelsDefault
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_cfg_valid,
    input  wire [2:0]           i_cfg_index,
    input  wire [31:0]          i_cfg_data,
    input  tasp_pkg::t_in_word  i_in,
    input  tasp_pkg::t_cmd      i_cmd,
    output tasp_pkg::t_sts      o_sts,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output tasp_pkg::t_out_word o_out
);
    import tasp_pkg::*;

    // configuration
    logic [2:0]  r_fmt;
    logic [31:0] r_chan_en;
    logic [11:0] r_qlvl;
    logic [7:0]  r_qfrm;
    logic [31:0] r_intv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt     <= FmtRaw;
            r_chan_en <= '0;
            r_qlvl    <= 12'd410;
            r_qfrm    <= 8'd20;
            r_intv    <= 32'd1000000;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                RegFormat:    r_fmt     <= i_cfg_data[2:0];
                RegChanEn:    r_chan_en <= i_cfg_data;
                RegQuietLvl:  r_qlvl    <= i_cfg_data[11:0];
                RegQuietFrm:  r_qfrm    <= i_cfg_data[7:0];
                RegStampIntv: r_intv    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // captured word
    t_in_word r_in;
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_in <= i_in;
    end

    logic signed [12:0] w_v;
    logic               w_en;
    assign w_v  = $signed({1'b0, r_in.sample}) - 13'sd2048;
    assign w_en = (32'(r_in.channel) < 32'(MAX_CHANNELS)) && r_chan_en[r_in.channel];

    // frame state
    logic [5:0]  r_fill;
    logic        r_loud;
    logic [7:0]  r_qrun;
    logic [63:0] r_next;
    logic [15:0] r_bits;
    logic [7:0]  r_codes [CodeDepth];
    logic [2:0]  r_sidx;
    logic [5:0]  r_midx;
    logic [7:0]  r_mem_q;

    logic w_full, w_loud_s, w_frame_loud;
    logic [7:0] w_qrun_nx;
    assign w_full   = (32'(r_fill) >= 32'(MAX_CHANNELS));
    assign w_loud_s = (w_v > $signed({1'b0, r_qlvl})) || (w_v < -$signed({1'b0, r_qlvl}));
    // loudness including the sample of this word when it is buffered
    logic w_store;
    assign w_store      = w_en && r_fmt == FmtTagged && !w_full;
    assign w_frame_loud = r_loud || (w_store && w_loud_s);
    assign w_qrun_nx    = w_frame_loud ? 8'd0 : (r_qrun == 8'hFF ? r_qrun : r_qrun + 8'd1);

    // buffered code write happens on the frame state update step;
    // read data is taken when the controller steps to the next code
    always_ff @(posedge i_clk) begin
        if (i_cmd.frame_upd && w_store) r_codes[r_fill[4:0]] <= enc_alaw(w_v);
        if (i_cmd.mem_nxt) r_mem_q <= r_codes[r_midx[4:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_loud <= 1'b0;
            r_qrun <= '0;
            r_next <= '0;
            r_bits <= '0;
            r_sidx <= '0;
            r_midx <= '0;
        end else begin
            if (i_cmd.load) begin
                r_sidx <= '0;
                r_midx <= '0;
            end
            if (i_cmd.stamp_nxt) r_sidx <= r_sidx + 3'd1;
            if (i_cmd.mem_nxt)   r_midx <= r_midx + 6'd1;
            if (i_cmd.tag_stamp) r_next <= r_in.now_usec + 64'(r_intv);
            if (i_cmd.drop)      r_next <= '0;
            if (i_cmd.frame_upd) begin
                if (r_in.frame_end) begin
                    if (r_fmt == FmtTagged) r_qrun <= w_qrun_nx;
                    r_fill <= '0;
                    r_loud <= 1'b0;
                    r_bits <= '0;
                end else begin
                    if (w_store) begin
                        r_fill <= r_fill + 6'd1;
                        r_loud <= w_frame_loud;
                    end
                    if (w_en && r_fmt == FmtBits && !r_in.channel[4] && r_in.sample != '0)
                        r_bits[r_in.channel[3:0]] <= 1'b1;
                end
            end
        end
    end

    // bit word including this word's bit
    logic [15:0] w_bits;
    always_comb begin
        w_bits = r_bits;
        if (w_en && r_fmt == FmtBits && !r_in.channel[4] && r_in.sample != '0)
            w_bits[r_in.channel[3:0]] = 1'b1;
    end

    // bit word held for the frame end bytes
    logic [15:0] r_bword;
    always_ff @(posedge i_clk) begin
        if (i_cmd.frame_upd) r_bword <= w_bits;
    end

    // fill after this word's code (frame end path)
    logic [5:0] w_fill_eff;
    assign w_fill_eff = r_fill + 6'(w_store);

    // status
    always_comb begin
        o_sts.en        = w_en;
        o_sts.fmt       = r_fmt;
        o_sts.fend      = r_in.frame_end;
        o_sts.full      = w_full;
        o_sts.drop      = (w_qrun_nx >= r_qfrm);
        o_sts.stamp_due = (r_in.now_usec >= r_next);
        o_sts.fill      = w_fill_eff;
        o_sts.stamp_idx = r_sidx;
        o_sts.mem_idx   = r_midx;
        o_sts.out_busy  = o_out_valid && !i_out_ready;
    end

    // byte selection
    logic [7:0] w_byte;
    logic [15:0] w_word;
    always_comb begin
        w_word = 16'(r_in.sample);
        if (r_fmt == FmtSigned) w_word = 16'($signed(w_v));
        if (r_fmt == FmtBits)   w_word = r_bword;
        case (i_cmd.src)
            SRC_LO:    w_byte = w_word[7:0];
            SRC_HI:    w_byte = w_word[15:8];
            SRC_CODE:  w_byte = (r_fmt == FmtXlaw) ? enc_xlaw(r_in.sample) : enc_alaw(w_v);
            SRC_ESC:   w_byte = EscByte;
            SRC_ZERO:  w_byte = 8'h00;
            SRC_STAMP: w_byte = r_in.now_usec[{r_sidx, 3'b000} +: 8];
            SRC_MEM:   w_byte = r_mem_q;
            default:   w_byte = 8'h00;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_out.out_byte <= w_byte;
            o_out.run_last <= i_cmd.last;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/tasp_ctrl.sv =====
// controller of the tagged a-law sample packer: sequences the bytes of
// each word; depends on tasp_pkg
`default_nettype none
module tasp_ctrl (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_in_valid,
    output logic           o_in_ready,
    output tasp_pkg::t_cmd o_cmd,
    input  tasp_pkg::t_sts i_sts
);
    import tasp_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_DEC   = 7'b0000010,
        S_HI    = 7'b0000100,
        S_FEND  = 7'b0001000,
        S_ZERO  = 7'b0010000,
        S_STAMP = 7'b0100000,
        S_MEM   = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic   r_tail, n_tail;   // a frame end follows the sample bytes
    logic   r_memrd, n_memrd; // buffer read data is valid
    logic   r_drop, n_drop;
    logic   r_stamp, n_stamp;
    logic   r_fill_z, n_fill_z;
    logic [5:0] r_fill, n_fill;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_tail  <= 1'b0;
            r_memrd <= 1'b0;
            r_drop  <= 1'b0;
            r_stamp <= 1'b0;
            r_fill_z <= 1'b0;
            r_fill  <= '0;
        end else begin
            r_state <= n_state;
            r_tail  <= n_tail;
            r_memrd <= n_memrd;
            r_drop  <= n_drop;
            r_stamp <= n_stamp;
            r_fill_z <= n_fill_z;
            r_fill  <= n_fill;
        end
    end

    // frame end in a format that may send frame bytes
    logic w_fend_bytes;
    assign w_fend_bytes = i_sts.fend && (i_sts.fmt == FmtBits || i_sts.fmt == FmtTagged);

    logic w_tagged_out;
    always_comb begin
        n_state  = r_state;
        n_tail   = r_tail;
        n_memrd  = 1'b0;
        n_drop   = r_drop;
        n_stamp  = r_stamp;
        n_fill_z = r_fill_z;
        n_fill   = r_fill;
        o_in_ready = 1'b0;
        o_cmd    = '0;
        o_cmd.src = SRC_LO;
        w_tagged_out = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DEC;
                end
            end
            S_DEC: begin
                // decide the sample bytes and frame action; state update once
                if (!i_sts.out_busy) begin
                    o_cmd.frame_upd = 1'b1;
                    n_tail  = w_fend_bytes;
                    n_drop  = i_sts.drop;
                    n_stamp = i_sts.stamp_due;
                    n_fill  = i_sts.fill;
                    n_fill_z = (i_sts.fill == '0);
                    n_state = S_FEND;
                    if (i_sts.en && (i_sts.fmt == FmtRaw || i_sts.fmt == FmtSigned)) begin
                        o_cmd.emit = 1'b1;
                        o_cmd.src  = SRC_LO;
                        n_state    = S_HI;
                    end else if (i_sts.en && (i_sts.fmt == FmtAlaw || i_sts.fmt == FmtXlaw)) begin
                        o_cmd.emit = 1'b1;
                        o_cmd.src  = SRC_CODE;
                        o_cmd.last = 1'b1;
                        n_state    = S_IDLE;
                    end else if (!w_fend_bytes) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_HI: begin
                if (!i_sts.out_busy) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.src  = SRC_HI;
                    o_cmd.last = !r_tail;
                    n_state    = r_tail ? S_FEND : S_IDLE;
                end
            end
            S_FEND: begin
                // frame end bytes; bit word bytes come from the word held at frame end
                if (!i_sts.out_busy) begin
                    if (i_sts.fmt == FmtBits) begin
                        o_cmd.emit = 1'b1;
                        o_cmd.src  = SRC_LO;
                        n_state    = S_HI;
                        n_tail     = 1'b0;
                    end else if (i_sts.fmt == FmtTagged) begin
                        if (r_drop) begin
                            o_cmd.drop = 1'b1;
                            w_tagged_out = 1'b1;
                        end else if (r_stamp) begin
                            o_cmd.emit      = 1'b1;
                            o_cmd.src       = SRC_ESC;
                            o_cmd.tag_stamp = 1'b1;
                            n_state         = S_ZERO;
                        end else if (r_fill_z) begin
                            w_tagged_out = 1'b1;
                        end else begin
                            o_cmd.mem_nxt = 1'b1;
                            n_memrd       = 1'b1;
                            n_state       = S_MEM;
                        end
                    end else begin
                        w_tagged_out = 1'b1;
                    end
                    if (w_tagged_out) begin
                        // no bytes at frame end
                        n_state = S_IDLE;
                    end
                end
            end
            S_ZERO: begin
                if (!i_sts.out_busy) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.src  = SRC_ZERO;
                    n_state    = S_STAMP;
                end
            end
            S_STAMP: begin
                if (!i_sts.out_busy) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.src       = SRC_STAMP;
                    o_cmd.stamp_nxt = 1'b1;
                    if (i_sts.stamp_idx == 3'd7) begin
                        if (r_fill_z) begin
                            o_cmd.last = 1'b1;
                            n_state    = S_IDLE;
                        end else begin
                            o_cmd.mem_nxt = 1'b1;
                            n_memrd       = 1'b1;
                            n_state       = S_MEM;
                        end
                    end
                end
            end
            S_MEM: begin
                // read data is taken with each step of the index
                n_memrd = r_memrd;
                if (r_memrd && !i_sts.out_busy) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.src  = SRC_MEM;
                    if (i_sts.mem_idx == r_fill) begin
                        o_cmd.last = 1'b1;
                        n_state    = S_IDLE;
                    end else begin
                        o_cmd.mem_nxt = 1'b1;
                        n_memrd       = 1'b1;
                    end
                end else if (!r_memrd) begin
                    n_memrd = 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/tagged_alaw_sample_packer.sv =====
// Tagged a-law sample packer, top level. Depends on tasp_pkg, tasp_ctrl
// and tasp_datapath.
//
// One input word is taken at a time. A raw or signed sample gives two bytes,
// an a-law or x-law sample one byte, and a word that gives nothing none. A
// frame end in the bit word format gives two bytes. A tagged a-law frame end
// gives no bytes when the frame is dropped or has no codes and no tag, one
// byte per code without a tag, and with a tag an escape byte, a zero byte
// and eight stamp bytes ahead of the codes. The output register holds each
// byte until taken; a stalled output pauses the sequencer. The last byte a
// word causes carries run_last.
`default_nettype none
module tagged_alaw_sample_packer #(
    parameter int MAX_CHANNELS = tasp_pkg::MaxChannelsDefault
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_cfg_valid,
    output logic                o_cfg_ready,
    input  wire [2:0]           i_cfg_index,
    input  wire [31:0]          i_cfg_data,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  tasp_pkg::t_in_word  i_in_data,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output tasp_pkg::t_out_word o_out_data
);
    import tasp_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    assign o_cfg_ready = 1'b1;

    tasp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .o_cmd      (w_cmd),
        .i_sts      (w_sts)
    );

    tasp_datapath #(.MAX_CHANNELS(MAX_CHANNELS)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (i_in_data),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out_data)
    );

endmodule
`default_nettype wire

// ===== rtl/tasp_checker.sv =====
// port-level checker for the tagged a-law sample packer, with its bind
// depends on tasp_pkg
`default_nettype none
module tasp_checker (
    input wire                 i_clk,
    input wire                 i_rst_n,
    input wire                 i_in_valid,
    input wire                 o_in_ready,
    input wire                 o_out_valid,
    input wire                 i_out_ready,
    input tasp_pkg::t_out_word o_out_data
);
    // no new word while a byte waits
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("output word changed while stalled");
    // accept leads to work: not ready the next cycle
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("word accepted while busy");
    // ready for a new word only once the waiting byte is the last of its run
    a_idle_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready && o_out_valid |-> o_out_data.run_last)
        else $error("ready while a run is unfinished");
endmodule

bind tagged_alaw_sample_packer tasp_checker u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
`default_nettype wire

// ===== test/tagged_alaw_sample_packer_chk.sv =====
`timescale 1ns / 1ps
// checker for the tagged a-law sample packer: watches the config, sample and byte
// channels, predicts the byte stream and compares each byte; depends on tasp_pkg
module tagged_alaw_sample_packer_chk (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_cfg_valid,
    input  wire                 i_cfg_ready,
    input  wire [2:0]           i_cfg_index,
    input  wire [31:0]          i_cfg_data,
    input  wire                 i_in_valid,
    input  wire                 i_in_ready,
    input  tasp_pkg::t_in_word  i_in_data,
    input  wire                 i_out_valid,
    input  wire                 i_out_ready,
    input  tasp_pkg::t_out_word i_out_data,
    output int                  o_fail_count,
    output int                  o_pending,
    output int                  o_bytes_seen
);
    import tasp_pkg::*;

    // shadow registers
    logic [2:0]  fmt_reg;
    logic [31:0] enable_reg;
    logic [11:0] quiet_lvl_reg;
    logic [7:0]  quiet_frm_reg;
    logic [31:0] stamp_intv_reg;

    // shadow frame state
    logic [7:0]  code_buf [32];
    int          code_fill;
    bit          loud_seen;
    int          quiet_count;
    logic [63:0] stamp_due_at;
    logic [15:0] bits_acc;

    t_out_word   byte_queue [$];

    // a-law code of a centred value, normalised by shifting
    function automatic logic [7:0] alaw_of(input int v);
        int sgn, mag, ex;
        sgn = (v < 0) ? 0 : 'h80;
        mag = (v < 0) ? -v : v;
        ex  = 1;
        if (mag <= 'h0F) return 8'((mag | sgn) ^ EscByte);
        if (mag > 'h7FF) mag = 'h7FF;
        while (mag > 'h1F) begin
            mag = mag >> 1;
            ex++;
        end
        return 8'(((mag & 'h0F) | (ex << 4) | sgn) ^ EscByte);
    endfunction

    // unsigned x-law code of a raw sample
    function automatic logic [7:0] xlaw_of(input int v);
        int ex;
        ex = 1;
        if (v <= 'h1F) return 8'(v);
        while (v > 'h3F) begin
            v = v >> 1;
            ex++;
        end
        return 8'((v & 'h1F) | (ex << 5));
    endfunction

    // push the bytes one accepted sample word causes
    task automatic predict_bytes(input t_in_word w);
        logic [7:0] bl [$];
        int         v;
        bit         en;
        t_out_word  o;
        v  = int'(w.sample) - 2048;
        en = enable_reg[w.channel];
        if (en) begin
            case (fmt_reg)
                FmtRaw: begin
                    bl.push_back(w.sample[7:0]);
                    bl.push_back({4'd0, w.sample[11:8]});
                end
                FmtSigned: begin
                    bl.push_back(8'(v));
                    bl.push_back(8'(v >> 8));
                end
                FmtAlaw: bl.push_back(alaw_of(v));
                FmtXlaw: bl.push_back(xlaw_of(int'(w.sample)));
                FmtBits: begin
                    if (w.channel < 16 && w.sample != 0) bits_acc[w.channel[3:0]] = 1'b1;
                end
                FmtTagged: begin
                    if (code_fill < 32) begin
                        code_buf[code_fill] = alaw_of(v);
                        code_fill++;
                        if (v > int'(quiet_lvl_reg) || v < -int'(quiet_lvl_reg))
                            loud_seen = 1;
                    end
                end
                default: ;
            endcase
        end
        if (w.frame_end) begin
            if (fmt_reg == FmtBits) begin
                bl.push_back(bits_acc[7:0]);
                bl.push_back(bits_acc[15:8]);
            end else if (fmt_reg == FmtTagged) begin
                if (loud_seen) quiet_count = 0;
                else if (quiet_count < 255) quiet_count++;
                if (quiet_count >= int'(quiet_frm_reg)) begin
                    stamp_due_at = '0;
                end else begin
                    if (w.now_usec >= stamp_due_at) begin
                        bl.push_back(EscByte);
                        bl.push_back(8'h00);
                        for (int k = 0; k < 8; k++) bl.push_back(w.now_usec[8*k +: 8]);
                        stamp_due_at = w.now_usec + 64'(stamp_intv_reg);
                    end
                    for (int k = 0; k < code_fill; k++) bl.push_back(code_buf[k]);
                end
            end
            code_fill = 0;
            loud_seen = 0;
            bits_acc  = '0;
        end
        foreach (bl[i]) begin
            o.out_byte = bl[i];
            o.run_last = (i == bl.size() - 1);
            byte_queue.push_back(o);
        end
    endtask

    // watch all three channels at each edge
    always @(posedge i_clk) begin
        t_out_word exp_w;
        if (!i_rst_n) begin
            fmt_reg        <= FmtRaw;
            enable_reg     <= '0;
            quiet_lvl_reg  <= 12'd410;
            quiet_frm_reg  <= 8'd20;
            stamp_intv_reg <= 32'd1000000;
            code_fill      = 0;
            loud_seen      = 0;
            quiet_count    = 0;
            stamp_due_at   = '0;
            bits_acc       = '0;
            byte_queue.delete();
            o_fail_count   <= 0;
            o_bytes_seen   <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    RegFormat:    fmt_reg        <= i_cfg_data[2:0];
                    RegChanEn:    enable_reg     <= i_cfg_data;
                    RegQuietLvl:  quiet_lvl_reg  <= i_cfg_data[11:0];
                    RegQuietFrm:  quiet_frm_reg  <= i_cfg_data[7:0];
                    RegStampIntv: stamp_intv_reg <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) predict_bytes(i_in_data);
            // compare one output word
            if (i_out_valid && i_out_ready) begin
                o_bytes_seen <= o_bytes_seen + 1;
                if (byte_queue.size() == 0) begin
                    $error("unexpected word: out_byte %0h run_last %0b",
                           i_out_data.out_byte, i_out_data.run_last);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_w = byte_queue.pop_front();
                    if (exp_w.out_byte !== i_out_data.out_byte) begin
                        $error("out_byte expected %0h actual %0h",
                               exp_w.out_byte, i_out_data.out_byte);
                        o_fail_count <= o_fail_count + 1;
                    end else if (exp_w.run_last !== i_out_data.run_last) begin
                        $error("run_last expected %0b actual %0b",
                               exp_w.run_last, i_out_data.run_last);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
        o_pending <= byte_queue.size();
    end

endmodule

// ===== test/tagged_alaw_sample_packer_tb.sv =====
`timescale 1ns / 1ps
// testbench top for the tagged a-law sample packer: drives config and sample words,
// stalls the byte side; uses tasp_pkg, the packer and tagged_alaw_sample_packer_chk
module tagged_alaw_sample_packer_tb;
    import tasp_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    t_in_word    in_data;
    logic        out_valid;
    logic        out_ready;
    t_out_word   out_data;
    int          fail_count;
    int          pending;
    int          bytes_seen;

    int          words_sent;
    int          burst_left;
    int          stall_pct;
    logic [31:0] cur_enable;
    logic [63:0] clock_usec;

    tagged_alaw_sample_packer dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_out_data(out_data)
    );

    tagged_alaw_sample_packer_chk chk (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .i_in_ready(in_ready), .i_in_data(in_data),
        .i_out_valid(out_valid), .i_out_ready(out_ready), .i_out_data(out_data),
        .o_fail_count(fail_count), .o_pending(pending), .o_bytes_seen(bytes_seen)
    );

    // clock
    always begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // receiver stall pattern: stall rate changes at random, among 0, 25, 60 and 90 percent
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
            stall_pct <= 0;
        end else begin
            if ($urandom_range(0, 63) == 0) begin
                case ($urandom_range(0, 3))
                    0: stall_pct <= 0;
                    1: stall_pct <= 25;
                    2: stall_pct <= 60;
                    default: stall_pct <= 90;
                endcase
            end
            out_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // one register write, block idle
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
        if (idx == RegChanEn) cur_enable = val;
    endtask

    // one sample word, sent in bursts with random gaps
    task automatic send_word(input logic [11:0] s, input logic [4:0] ch,
                             input bit fe, input logic [63:0] now);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 2) != 0) begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
        burst_left--;
        in_valid          <= 1'b1;
        in_data.sample    <= s;
        in_data.channel   <= ch;
        in_data.frame_end <= fe;
        in_data.now_usec  <= now;
        do @(posedge clk); while (!in_ready);
        words_sent++;
    endtask

    // drain all expected bytes, then let the block settle
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    task automatic set_all(input logic [2:0] f, input logic [31:0] en, input logic [11:0] ql,
                           input logic [7:0] qf, input logic [31:0] si);
        write_reg(RegFormat, {29'd0, f});
        write_reg(RegChanEn, en);
        write_reg(RegQuietLvl, {20'd0, ql});
        write_reg(RegQuietFrm, {24'd0, qf});
        write_reg(RegStampIntv, si);
    endtask

    function automatic logic [4:0] pick_channel();
        logic [4:0] c;
        for (int t = 0; t < 8; t++) begin
            c = 5'($urandom_range(0, 31));
            if (cur_enable[c]) return c;
        end
        return c;
    endfunction

    function automatic logic [11:0] pick_sample(input bit hush);
        case ($urandom_range(0, 9))
            0: return 12'd0;
            1: return 12'hFFF;
            default: return hush ? 12'(2048 + $urandom_range(0, 40) - 20)
                                 : 12'($urandom);
        endcase
    endfunction

    initial begin
        int nsamp;
        bit hush;
        rst_n      = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        in_valid   = 1'b0;
        in_data    = '0;
        words_sent = 0;
        burst_left = 0;
        cur_enable = '0;
        clock_usec = 64'd5;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes in each per-sample format
        for (int f = FmtRaw; f <= FmtXlaw; f++) begin
            set_all(3'(f), 32'hFFFF_FFFF, 12'd410, 8'd20, 32'd1000000);
            send_word(12'd0, 5'd0, 0, 64'd0);
            send_word(12'hFFF, 5'd31, 0, 64'd0);
            send_word(12'd2048, 5'd7, 0, 64'd0);
            send_word(12'd2047, 5'd8, 0, 64'd0);
            send_word(12'd2063, 5'd9, 1, 64'd0);
            wait_idle();
        end
        // bit word, only some channels enabled, and an empty frame
        set_all(FmtBits, 32'h0001_8005, 12'd0, 8'd0, 32'd0);
        send_word(12'd1, 5'd0, 0, 64'd0);
        send_word(12'd0, 5'd2, 0, 64'd0);
        send_word(12'd9, 5'd16, 0, 64'd0);
        send_word(12'd9, 5'd15, 1, 64'd0);
        send_word(12'd9, 5'd1, 1, 64'd0);
        wait_idle();
        // tagged: buffer overflow, stamp at all-ones time, quiet drop
        set_all(FmtTagged, 32'hFFFF_FFFF, 12'd2048, 8'd2, 32'hFFFF_FFFF);
        for (int i = 0; i < 34; i++) send_word(12'(i * 120), 5'(i), i == 33, 64'hFFFF_FFFF_FFFF_FFFF);
        send_word(12'd2048, 5'd3, 1, 64'd0);
        send_word(12'd2048, 5'd3, 1, 64'd0);
        send_word(12'd2048, 5'd3, 1, 64'd0);
        wait_idle();
        // unused formats still clear frame state
        write_reg(RegFormat, 32'd7);
        send_word(12'd100, 5'd1, 1, 64'd0);
        wait_idle();
        write_reg(RegFormat, 32'd6);
        send_word(12'd100, 5'd1, 1, 64'd0);
        wait_idle();

        // random phases
        while (words_sent < 410) begin
            case ($urandom_range(0, 3))
                0: write_reg(RegFormat, {29'd0, 3'($urandom_range(0, 7))});
                default: write_reg(RegFormat, {29'd0, FmtTagged});
            endcase
            case ($urandom_range(0, 4))
                0: write_reg(RegChanEn, 32'hFFFF_FFFF);
                1: write_reg(RegChanEn, 32'h0);
                2: write_reg(RegChanEn, 32'h1 << $urandom_range(0, 31));
                default: write_reg(RegChanEn, $urandom);
            endcase
            case ($urandom_range(0, 3))
                0: write_reg(RegQuietLvl, 32'd0);
                1: write_reg(RegQuietLvl, 32'd2048);
                2: write_reg(RegQuietLvl, 32'hFFF);
                default: write_reg(RegQuietLvl, 32'($urandom_range(20, 600)));
            endcase
            case ($urandom_range(0, 3))
                0: write_reg(RegQuietFrm, 32'd255);
                1: write_reg(RegQuietFrm, 32'($urandom_range(0, 255)));
                default: write_reg(RegQuietFrm, 32'($urandom_range(1, 3)));
            endcase
            case ($urandom_range(0, 3))
                0: write_reg(RegStampIntv, 32'd0);
                1: write_reg(RegStampIntv, 32'hFFFF_FFFF);
                default: write_reg(RegStampIntv, 32'($urandom_range(1, 300)));
            endcase
            repeat ($urandom_range(3, 8)) begin
                nsamp = $urandom_range(0, 6);
                hush  = ($urandom_range(0, 2) == 0);
                if ($urandom_range(0, 9) == 0) clock_usec = {$urandom, $urandom};
                else clock_usec += 64'($urandom_range(0, 200));
                for (int i = 0; i <= nsamp; i++) begin
                    if ($urandom_range(0, 9) == 0)
                        send_word(12'($urandom), 5'($urandom), 1'($urandom), {$urandom, $urandom});
                    else
                        send_word(pick_sample(hush), pick_channel(), i == nsamp, clock_usec);
                end
            end
            wait_idle();
        end

        $display("covered %0d sample words over all formats, %0d bytes checked",
                 words_sent, bytes_seen);
        if (fail_count == 0) begin
            $display("[tagged_alaw_sample_packer] OK");
        end else begin
            $display("[tagged_alaw_sample_packer] ERROR");
        end
        $finish;
    end

    // run limit
    initial begin
        #20000000;
        $display("[tagged_alaw_sample_packer] ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/tasp_pkg.sv
rtl/tasp_datapath.sv
rtl/tasp_ctrl.sv
rtl/tagged_alaw_sample_packer.sv
rtl/tasp_checker.sv
test/tagged_alaw_sample_packer_chk.sv
test/tagged_alaw_sample_packer_tb.sv
